/* sv/ibse_pkg.sv */
// Shared constants, types and the signature table of the interleaved section extractor.
package ibse_pkg;

  localparam int INTERLEAVE_BYTES = 288;
  localparam int SEARCH_LIMIT     = 100;
  localparam int HEADER_BYTES     = 13;
  localparam int MAX_IMAGES       = 8;

  localparam int OFFSET_W = $clog2(INTERLEAVE_BYTES + 1);
  localparam int SLOT_W   = 3;
  localparam int SEL_W    = 4;
  localparam int HDR_W    = 4;
  localparam int COUNT_W  = 7;
  localparam int LEN_W    = 19;
  localparam int ACC_W    = 32;
  localparam int LBL_W    = 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [HDR_W-1:0]   SIG_LEN      = HDR_W'(13);
  localparam logic [7:0]         NAME_FIRST   = 8'h61;
  localparam logic [7:0]         NAME_E       = 8'h65;
  localparam logic [ACC_W-1:0]   E_LEN_MAX    = ACC_W'(300 * 1024);
  localparam logic [ACC_W-1:0]   TEXT_LEN_MAX = ACC_W'(64);
  localparam logic [COUNT_W-1:0] COUNT_SAT    = COUNT_W'(127);

  localparam logic [0:0] REG_IMAGE_SELECT = 1'b0;
  localparam logic [0:0] REG_IMAGE_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_MISMATCH = 2'd1,
    KIND_NOTFOUND = 2'd2,
    KIND_FOUND    = 2'd3
  } kind_t;

  typedef enum logic [5:0] {
    PH_HEADER  = 6'b000001,
    PH_NAME    = 6'b000010,
    PH_LEN     = 6'b000100,
    PH_SKIP    = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic [7:0] sig_byte(input logic [HDR_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h00;
      4'd1:    b = 8'h09;
      4'd2:    b = 8'h0f;
      4'd3:    b = 8'hf0;
      4'd4:    b = 8'h0f;
      4'd5:    b = 8'hf0;
      4'd6:    b = 8'h0f;
      4'd7:    b = 8'hf0;
      4'd8:    b = 8'h0f;
      4'd9:    b = 8'hf0;
      4'd10:   b = 8'h00;
      4'd11:   b = 8'h00;
      4'd12:   b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* sv/ibse_front.sv */
// Front end: config registers, interleave tracking, selection of the chosen image's words.
module ibse_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [3:0]               cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               stream_byte,
  input  ibse_pkg::fifo_status_t   fifo_st,
  output logic                     push,
  output logic [7:0]               push_byte
);

  logic [ibse_pkg::SEL_W-1:0]    image_select;
  logic [ibse_pkg::SEL_W-1:0]    image_count;
  logic [ibse_pkg::OFFSET_W-1:0] interleave_offset;
  logic [ibse_pkg::SLOT_W-1:0]   image_slot;
  logic [ibse_pkg::SEL_W-1:0]    count_eff;
  logic [ibse_pkg::SEL_W-1:0]    slot_inc;
  logic                          accept;
  logic                          mine;

  always_comb begin
    if (image_count == '0) begin
      count_eff = ibse_pkg::SEL_W'(1);
    end else if (image_count > ibse_pkg::SEL_W'(ibse_pkg::MAX_IMAGES)) begin
      count_eff = ibse_pkg::SEL_W'(ibse_pkg::MAX_IMAGES);
    end else begin
      count_eff = image_count;
    end
  end

  assign slot_inc  = {1'b0, image_slot} + ibse_pkg::SEL_W'(1);
  assign mine      = (image_select != '0) && (image_select <= count_eff) &&
                     (slot_inc == image_select);
  assign in_ready  = !fifo_st.full;
  assign accept    = in_valid && in_ready;
  assign push      = accept && mine;
  assign push_byte = stream_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_select <= ibse_pkg::SEL_W'(1);
      image_count  <= ibse_pkg::SEL_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == ibse_pkg::REG_IMAGE_SELECT) begin
        image_select <= cfg_data;
      end else begin
        image_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interleave_offset <= '0;
      image_slot        <= '0;
    end else if (accept) begin
      if (interleave_offset == ibse_pkg::OFFSET_W'(ibse_pkg::INTERLEAVE_BYTES - 1)) begin
        interleave_offset <= '0;
        if (slot_inc >= count_eff) begin
          image_slot <= '0;
        end else begin
          image_slot <= slot_inc[ibse_pkg::SLOT_W-1:0];
        end
      end else begin
        interleave_offset <= interleave_offset + ibse_pkg::OFFSET_W'(1);
      end
    end
  end

endmodule

/* sv/ibse_fifo.sv */
// Short word queue between front and back.
module ibse_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [7:0]             push_byte,
  input  logic                   pop,
  output logic [7:0]             pop_byte,
  output ibse_pkg::fifo_status_t status
);

  logic [7:0]                   entries [ibse_pkg::FIFO_DEPTH];
  logic [ibse_pkg::FIFO_AW-1:0] wptr;
  logic [ibse_pkg::FIFO_AW-1:0] rptr;
  logic [ibse_pkg::FIFO_AW:0]   count;

  assign status.full  = (count == (ibse_pkg::FIFO_AW+1)'(ibse_pkg::FIFO_DEPTH));
  assign status.empty = (count == '0);
  assign pop_byte     = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + ibse_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rptr <= rptr + ibse_pkg::FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (ibse_pkg::FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (ibse_pkg::FIFO_AW+1)'(1);
      end
    end
  end

endmodule

/* sv/ibse_back.sv */
// Back end: header check, section walk and payload forwarding with an output register.
module ibse_back (
  input  logic                         clk,
  input  logic                         rst,
  input  ibse_pkg::fifo_status_t       fifo_st,
  input  logic [7:0]                   pop_byte,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   kind,
  output logic [7:0]                   data,
  output logic [ibse_pkg::LEN_W-1:0]   found_length,
  output logic                         last
);

  ibse_pkg::phase_t               phase, phase_next;
  logic [ibse_pkg::HDR_W-1:0]     header_index, header_index_next;
  logic [ibse_pkg::COUNT_W-1:0]   search_count, search_count_next;
  logic [ibse_pkg::COUNT_W-1:0]   count_inc;
  logic [ibse_pkg::ACC_W-1:0]     length_accum, length_accum_next;
  logic [ibse_pkg::LBL_W-1:0]     length_bytes_left, length_bytes_left_next;
  logic                           section_is_e, section_is_e_next;
  logic [ibse_pkg::LEN_W-1:0]     bytes_remaining, bytes_remaining_next;
  logic [ibse_pkg::LEN_W-1:0]     rem_dec;
  logic [ibse_pkg::HDR_W:0]       hdr_inc;
  logic [ibse_pkg::ACC_W-1:0]     acc_shift;
  logic [ibse_pkg::LEN_W-1:0]     e_len;
  logic [ibse_pkg::LEN_W-1:0]     text_len;
  logic                           emit;
  ibse_pkg::kind_t                emit_kind;
  logic [7:0]                     emit_data;
  logic [ibse_pkg::LEN_W-1:0]     emit_len;
  logic                           emit_last;

  assign pop = !fifo_st.empty && (!out_valid || out_ready);

  assign count_inc = (search_count < ibse_pkg::COUNT_SAT) ?
                     search_count + ibse_pkg::COUNT_W'(1) : search_count;
  assign rem_dec   = (bytes_remaining != '0) ?
                     bytes_remaining - ibse_pkg::LEN_W'(1) : bytes_remaining;
  assign hdr_inc   = {1'b0, header_index} + (ibse_pkg::HDR_W+1)'(1);
  assign acc_shift = {length_accum[ibse_pkg::ACC_W-9:0], pop_byte};
  assign e_len     = (acc_shift > ibse_pkg::E_LEN_MAX) ?
                     ibse_pkg::E_LEN_MAX[ibse_pkg::LEN_W-1:0] : acc_shift[ibse_pkg::LEN_W-1:0];
  assign text_len  = (acc_shift > ibse_pkg::TEXT_LEN_MAX) ?
                     ibse_pkg::TEXT_LEN_MAX[ibse_pkg::LEN_W-1:0] :
                     acc_shift[ibse_pkg::LEN_W-1:0];

  always_comb begin
    phase_next             = phase;
    header_index_next      = header_index;
    search_count_next      = search_count;
    length_accum_next      = length_accum;
    length_bytes_left_next = length_bytes_left;
    section_is_e_next      = section_is_e;
    bytes_remaining_next   = bytes_remaining;
    emit                   = 1'b0;
    emit_kind              = ibse_pkg::KIND_PAYLOAD;
    emit_data              = '0;
    emit_len               = '0;
    emit_last              = 1'b0;
    unique case (phase)
      ibse_pkg::PH_HEADER: begin
        if (header_index < ibse_pkg::SIG_LEN &&
            pop_byte != ibse_pkg::sig_byte(header_index)) begin
          emit      = 1'b1;
          emit_kind = ibse_pkg::KIND_MISMATCH;
          emit_last = 1'b1;
        end else begin
          header_index_next = hdr_inc[ibse_pkg::HDR_W-1:0];
          if (hdr_inc >= (ibse_pkg::HDR_W+1)'(ibse_pkg::HEADER_BYTES)) begin
            phase_next        = ibse_pkg::PH_NAME;
            search_count_next = '0;
          end
        end
      end
      ibse_pkg::PH_NAME: begin
        search_count_next = count_inc;
        if (pop_byte < ibse_pkg::NAME_FIRST || pop_byte > ibse_pkg::NAME_E) begin
          emit      = 1'b1;
          emit_kind = ibse_pkg::KIND_NOTFOUND;
          emit_last = 1'b1;
        end else begin
          section_is_e_next      = (pop_byte == ibse_pkg::NAME_E);
          length_bytes_left_next = (pop_byte == ibse_pkg::NAME_E) ?
                                   ibse_pkg::LBL_W'(4) : ibse_pkg::LBL_W'(2);
          length_accum_next      = '0;
          phase_next             = ibse_pkg::PH_LEN;
        end
      end
      ibse_pkg::PH_LEN: begin
        search_count_next = count_inc;
        length_accum_next = acc_shift;
        if (length_bytes_left > ibse_pkg::LBL_W'(1)) begin
          length_bytes_left_next = length_bytes_left - ibse_pkg::LBL_W'(1);
        end else begin
          length_bytes_left_next = '0;
          if (section_is_e) begin
            emit      = 1'b1;
            emit_kind = ibse_pkg::KIND_FOUND;
            emit_len  = e_len;
            if (e_len == '0) begin
              emit_last = 1'b1;
            end else begin
              bytes_remaining_next = e_len;
              phase_next           = ibse_pkg::PH_PAYLOAD;
            end
          end else if (count_inc >= ibse_pkg::COUNT_W'(ibse_pkg::SEARCH_LIMIT)) begin
            emit      = 1'b1;
            emit_kind = ibse_pkg::KIND_NOTFOUND;
            emit_last = 1'b1;
          end else if (text_len == '0) begin
            phase_next = ibse_pkg::PH_NAME;
          end else begin
            bytes_remaining_next = text_len;
            phase_next           = ibse_pkg::PH_SKIP;
          end
        end
      end
      ibse_pkg::PH_SKIP: begin
        search_count_next    = count_inc;
        bytes_remaining_next = rem_dec;
        if (count_inc >= ibse_pkg::COUNT_W'(ibse_pkg::SEARCH_LIMIT)) begin
          emit      = 1'b1;
          emit_kind = ibse_pkg::KIND_NOTFOUND;
          emit_last = 1'b1;
        end else if (rem_dec == '0) begin
          phase_next = ibse_pkg::PH_NAME;
        end
      end
      ibse_pkg::PH_PAYLOAD: begin
        bytes_remaining_next = rem_dec;
        emit                 = 1'b1;
        emit_kind            = ibse_pkg::KIND_PAYLOAD;
        emit_data            = pop_byte;
        emit_last            = (rem_dec == '0);
      end
      ibse_pkg::PH_DONE: begin
      end
      default: begin
        phase_next = ibse_pkg::PH_DONE;
      end
    endcase
    if (emit_last) begin
      phase_next = ibse_pkg::PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= ibse_pkg::PH_HEADER;
      header_index      <= '0;
      search_count      <= '0;
      length_accum      <= '0;
      length_bytes_left <= '0;
      section_is_e      <= 1'b0;
      bytes_remaining   <= '0;
    end else if (pop) begin
      phase             <= phase_next;
      header_index      <= header_index_next;
      search_count      <= search_count_next;
      length_accum      <= length_accum_next;
      length_bytes_left <= length_bytes_left_next;
      section_is_e      <= section_is_e_next;
      bytes_remaining   <= bytes_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      kind         <= emit_kind;
      data         <= emit_data;
      found_length <= emit_len;
      last         <= emit_last;
    end
  end

endmodule

/* sv/interleaved_bitfile_section_extractor_top.sv */
// Top level of the interleaved section extractor: front, word queue, back.
//
//   channel   direction  handshake            words
//   input     in         in_valid/in_ready    stream_byte
//   output    out        out_valid/out_ready  kind, data, found_length, last
//   config    in         cfg_we               cfg_index, cfg_data
//
// One input word per cycle while the queue is not full; each result is registered in the back end's
// output register. Rate is set by the four-word queue and the parser step in the back end.
// Synchronous reset clears config to image 1 of 1 and restarts the header check.
// Input stalls only when the queue is full; the back end stalls on out_ready.
// After a result with last set, input is taken and dropped until reset.
module interleaved_bitfile_section_extractor_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [3:0]                 cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 stream_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 kind,
  output logic [7:0]                 data,
  output logic [ibse_pkg::LEN_W-1:0] found_length,
  output logic                       last
);

  ibse_pkg::fifo_status_t fifo_st;
  logic                   push;
  logic [7:0]             push_byte;
  logic                   pop;
  logic [7:0]             pop_byte;

  ibse_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .fifo_st     (fifo_st),
    .push        (push),
    .push_byte   (push_byte)
  );

  ibse_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_byte (push_byte),
    .pop       (pop),
    .pop_byte  (pop_byte),
    .status    (fifo_st)
  );

  ibse_back u_back (
    .clk          (clk),
    .rst          (rst),
    .fifo_st      (fifo_st),
    .pop_byte     (pop_byte),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .data         (data),
    .found_length (found_length),
    .last         (last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && fifo_st.full && !pop))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && fifo_st.empty))
    else $error("queue underflow");

  a_quiet_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> !out_valid)
    else $error("result after final word");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == ibse_pkg::KIND_MISMATCH || kind == ibse_pkg::KIND_NOTFOUND)
      |-> last && data == '0 && found_length == '0)
    else $error("error result not final");

endmodule
